>>> rtl/wf3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wf3_pkg;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 11;
  localparam int KERN_W = 63;
  localparam int IDX_W  = 3;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_KERN_A   = 3'd1;
  localparam logic [IDX_W-1:0] REG_KERN_B   = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd4;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  // floor(x / 9) for x <= 2295 as (x * 3641) >> 15
  localparam int MEAN_RECIP = 3641;
  localparam int MEAN_SHIFT = 15;
  localparam int SUM_W      = 12;

  localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
  localparam logic [PIX_W-1:0] LVL_1    = 8'd85;
  localparam logic [PIX_W-1:0] LVL_2    = 8'd170;
  localparam logic [PIX_W-1:0] THR_1    = 8'd64;
  localparam logic [PIX_W-1:0] THR_2    = 8'd128;
  localparam logic [PIX_W-1:0] THR_3    = 8'd192;

  typedef enum logic [1:0] {
    MODE_MEAN      = 2'd0,
    MODE_KERNEL    = 2'd1,
    MODE_GRAD      = 2'd2,
    MODE_GRAD_POST = 2'd3
  } mode_e;

  // window pixel k = 3*row + col, row 0 top, col 0 left
  typedef logic [8:0][PIX_W-1:0] pix9_t;
  typedef logic [2:0][PIX_W-1:0] val3_t;

  // per-pixel bookkeeping that travels down the arithmetic pipe
  typedef struct packed {
    logic [2:0]       emit;      // result slots: (r-1,c-1), (r-1,c), (r,c)
    logic             interior;
    logic             frame_end;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] px;
  } meta_t;

  function automatic logic [PIX_W-1:0] posterize_inv(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] x;
    x = ~v;
    if (x < THR_1) return '0;
    else if (x < THR_2) return LVL_1;
    else if (x < THR_3) return LVL_2;
    else return PIX_MAX;
  endfunction

  function automatic logic [PIX_W-1:0] border_val(input mode_e m, input logic [PIX_W-1:0] p);
    logic [PIX_W-1:0] r;
    case (m)
      MODE_MEAN:      r = '0;
      MODE_GRAD_POST: r = posterize_inv(p);
      default:        r = p;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/window_filter_3x3.sv
`timescale 1ns / 1ps
`default_nettype none

// 3x3 neighbourhood filter on a raster-order grey pixel stream. Pixels enter one per clock;
// each pixel is read against two line buffers (one read and one write per buffer per cycle)
// and a six-register window, then passes a four-stage pipe (buffer read, products, sums,
// result register) before its results appear. Row 0, and column 0 above the last row, give no
// result; other pixels give one, the last column two and the last row up to three each. The
// output moves one result per clock when not stalled, so such pixels hold the input off. The
// sustained rate is one pixel per cycle within any row but the last, without output stalls,
// set by the single output register. Results carry row and column and leave in raster order
// of the centre pixel but for the last two rows, which interleave; the bottom-right result
// carries frame_end. The line buffers are not cleared: no result of a frame of constant size
// depends on their old contents. Write configuration only while the block is idle.
module window_filter_3x3
  import wf3_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int COEF_BITS  = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [KERN_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [PIX_W-1:0]  pixel_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [PIX_W-1:0]       value_o,
  output logic [ROW_W-1:0]       out_row_o,
  output logic [COL_W-1:0]       out_col_o,
  output logic                   frame_end_o
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  // configuration
  mode_e              mode_q;
  logic [KERN_W-1:0]  kern_a_q, kern_b_q;
  logic [11:0]        width_q;
  logic [12:0]        height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MEAN;
      kern_a_q <= '0;
      kern_b_q <= '0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:   mode_q   <= mode_e'(cfg_data_i[1:0]);
        REG_KERN_A: kern_a_q <= cfg_data_i;
        REG_KERN_B: kern_b_q <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i[11:0];
        REG_HEIGHT: height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_comb begin
    if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else if (width_q < 12'd3) w_eff = CW'(3);
    else w_eff = CW'(width_q);
    if (32'(height_q) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else if (height_q < 13'd3) h_eff = RW'(3);
    else h_eff = RW'(height_q);
  end

  // pipeline advance: all stages move together when the result register can take an item
  logic       en, accept;
  logic [2:0] fin_mask_q;
  logic       fin_last;

  assign fin_last   = (fin_mask_q & (fin_mask_q - 3'd1)) == 3'd0;
  assign en         = (fin_mask_q == 3'd0) || (fin_last && !out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // raster position
  logic [CW-1:0] col_q, col_d, cc;
  logic [RW-1:0] row_q, row_d, rr0, rr;

  always_comb begin
    if (col_q >= w_eff) begin
      cc  = '0;
      rr0 = row_q + RW'(1);
    end else begin
      cc  = col_q;
      rr0 = row_q;
    end
    rr    = (rr0 >= h_eff) ? '0 : rr0;
    col_d = cc + CW'(1);
    row_d = rr;
    if (col_d == w_eff) begin
      col_d = '0;
      row_d = rr + RW'(1);
      if (row_d == h_eff) row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line buffers; lower takes the new pixel at once, upper takes the old lower one stage on
  logic [PIX_W-1:0] lb_upper [MAX_WIDTH];
  logic [PIX_W-1:0] lb_lower [MAX_WIDTH];
  logic [PIX_W-1:0] rd_up_q, rd_lo_q;
  logic [AW-1:0]    addr;

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [CW-1:0]    s1_c_q;
  logic [RW-1:0]    s1_r_q;

  assign addr = cc[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_lo_q        <= lb_lower[addr];
      lb_lower[addr] <= pixel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) rd_up_q <= lb_upper[addr];
    if (en && s1_valid_q) lb_upper[s1_c_q[AW-1:0]] <= rd_lo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (en) s1_valid_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q <= pixel_i;
      s1_c_q  <= cc;
      s1_r_q  <= rr;
    end
  end

  // window: [0..2] centre column top to bottom, [3..5] left column
  logic [PIX_W-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (en && s1_valid_q) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= rd_up_q;
      win_q[1] <= rd_lo_q;
      win_q[2] <= s1_px_q;
    end
  end

  pix9_t win;
  meta_t s1_meta;
  logic  last_col;

  always_comb begin
    win[0] = win_q[3]; win[1] = win_q[0]; win[2] = rd_up_q;
    win[3] = win_q[4]; win[4] = win_q[1]; win[5] = rd_lo_q;
    win[6] = win_q[5]; win[7] = win_q[2]; win[8] = s1_px_q;

    last_col           = s1_c_q == w_eff - CW'(1);
    s1_meta.emit[0]    = (s1_r_q != '0) && (s1_c_q != '0);
    s1_meta.emit[1]    = (s1_r_q != '0) && last_col;
    s1_meta.emit[2]    = s1_r_q == h_eff - RW'(1);
    s1_meta.interior   = (s1_r_q >= RW'(2)) && (s1_c_q >= CW'(2));
    s1_meta.frame_end  = last_col;
    s1_meta.row        = ROW_W'(s1_r_q);
    s1_meta.col        = COL_W'(s1_c_q);
    s1_meta.centre     = win_q[1];
    s1_meta.lo         = rd_lo_q;
    s1_meta.px         = s1_px_q;
  end

  logic  calc_valid;
  val3_t calc_vals;
  meta_t calc_meta;

  wf3_calc #(
    .COEF_BITS (COEF_BITS)
  ) u_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s1_valid_q),
    .win_i    (win),
    .meta_i   (s1_meta),
    .mode_i   (mode_q),
    .kern_a_i (kern_a_q),
    .kern_b_i (kern_b_q),
    .valid_o  (calc_valid),
    .vals_o   (calc_vals),
    .meta_o   (calc_meta)
  );

  // result register, drained one slot per transfer
  val3_t            fin_vals_q;
  logic [ROW_W-1:0] fin_row_q;
  logic [COL_W-1:0] fin_col_q;
  logic             fin_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fin_mask_q <= '0;
    else if (en) fin_mask_q <= calc_valid ? calc_meta.emit : 3'b000;
    else if (!out_stall_i) fin_mask_q <= fin_mask_q & (fin_mask_q - 3'd1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_vals_q <= calc_vals;
      fin_row_q  <= calc_meta.row;
      fin_col_q  <= calc_meta.col;
      fin_end_q  <= calc_meta.frame_end;
    end
  end

  assign out_valid_o = fin_mask_q != 3'b000;

  always_comb begin
    if (fin_mask_q[0]) begin
      value_o     = fin_vals_q[0];
      out_row_o   = fin_row_q - ROW_W'(1);
      out_col_o   = fin_col_q - COL_W'(1);
      frame_end_o = 1'b0;
    end else if (fin_mask_q[1]) begin
      value_o     = fin_vals_q[1];
      out_row_o   = fin_row_q - ROW_W'(1);
      out_col_o   = fin_col_q;
      frame_end_o = 1'b0;
    end else begin
      value_o     = fin_vals_q[2];
      out_row_o   = fin_row_q;
      out_col_o   = fin_col_q;
      frame_end_o = fin_end_q && fin_mask_q[2];
    end
  end

endmodule

`default_nettype wire

>>> rtl/wf3_calc.sv
`timescale 1ns / 1ps
`default_nettype none

module wf3_calc
  import wf3_pkg::*;
#(
  parameter int COEF_BITS = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire pix9_t             win_i,
  input  wire meta_t             meta_i,
  input  wire mode_e             mode_i,
  input  wire logic [KERN_W-1:0] kern_a_i,
  input  wire logic [KERN_W-1:0] kern_b_i,
  output logic                   valid_o,
  output val3_t                  vals_o,
  output meta_t                  meta_o
);

  localparam int PW = COEF_BITS + PIX_W + 1;  // signed coef x unsigned pixel
  localparam int SW = PW + 4;                 // nine-term sum

  // stage A: products
  logic                 a_valid_q;
  meta_t                a_meta_q;
  logic signed [PW-1:0] prod_a_q [9];
  logic signed [PW-1:0] prod_b_q [9];
  logic [SUM_W-1:0]     psum_q, psum_d;

  // stage B: sums
  logic                 b_valid_q;
  meta_t                b_meta_q;
  logic signed [SW-1:0] sa_q, sb_q, sa_d, sb_d;
  logic [SUM_W-1:0]     bsum_q;

  always_comb begin
    psum_d = '0;
    for (int k = 0; k < 9; k++) psum_d = psum_d + SUM_W'(win_i[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_meta_q <= meta_i;
      psum_q   <= psum_d;
      for (int k = 0; k < 9; k++) begin
        prod_a_q[k] <= PW'($signed(kern_a_i[k*COEF_BITS +: COEF_BITS]))
                     * PW'($signed({1'b0, win_i[k]}));
        prod_b_q[k] <= PW'($signed(kern_b_i[k*COEF_BITS +: COEF_BITS]))
                     * PW'($signed({1'b0, win_i[k]}));
      end
    end
  end

  always_comb begin
    sa_d = '0;
    sb_d = '0;
    for (int k = 0; k < 9; k++) begin
      sa_d = sa_d + SW'(prod_a_q[k]);
      sb_d = sb_d + SW'(prod_b_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_meta_q <= a_meta_q;
      sa_q     <= sa_d;
      sb_q     <= sb_d;
      bsum_q   <= psum_q;
    end
  end

  // final selection
  logic [2*SUM_W-1:0]   mean_prod;
  logic [PIX_W-1:0]     mean_v, single_v, grad_v, inner_v;
  logic signed [SW-1:0] abs_a, abs_b;
  logic [SW:0]          mag;

  always_comb begin
    mean_prod = (2*SUM_W)'(bsum_q) * (2*SUM_W)'(MEAN_RECIP);
    mean_v    = mean_prod[MEAN_SHIFT +: PIX_W];

    if (sa_q < 0) single_v = '0;
    else if (sa_q > SW'(PIX_MAX)) single_v = PIX_MAX;
    else single_v = sa_q[PIX_W-1:0];

    abs_a = (sa_q < 0) ? -sa_q : sa_q;
    abs_b = (sb_q < 0) ? -sb_q : sb_q;
    mag   = (SW+1)'(unsigned'(abs_a)) + (SW+1)'(unsigned'(abs_b));
    grad_v = (mag > (SW+1)'(PIX_MAX)) ? PIX_MAX : mag[PIX_W-1:0];

    case (mode_i)
      MODE_MEAN:      inner_v = mean_v;
      MODE_KERNEL:    inner_v = single_v;
      MODE_GRAD:      inner_v = grad_v;
      MODE_GRAD_POST: inner_v = posterize_inv(grad_v);
      default:        inner_v = grad_v;
    endcase

    vals_o[0] = b_meta_q.interior ? inner_v : border_val(mode_i, b_meta_q.centre);
    vals_o[1] = border_val(mode_i, b_meta_q.lo);
    vals_o[2] = border_val(mode_i, b_meta_q.px);
  end

  assign valid_o = b_valid_q;
  assign meta_o  = b_meta_q;

endmodule

`default_nettype wire

>>> rtl/wf3_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wf3_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  value_o,
  input wire logic [11:0] out_row_o,
  input wire logic [10:0] out_col_o,
  input wire logic        frame_end_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(out_row_o)
      && $stable(out_col_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // with no result pending the input is never held off
  a_idle_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a frame has at least three rows, so two frame ends never follow each other
  a_single_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_end_o |=> !(out_valid_o && frame_end_o))
    else $error("frame end repeated");

endmodule

bind window_filter_3x3 wf3_checker u_wf3_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wf3_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_end;
  } filt_res_t;

  typedef enum int {KS_WIDE, KS_SMALL, KS_CORNERS} kern_style_e;

  localparam int LB_DEPTH     = 2048;
  localparam int ROWS_MAX     = 4096;
  localparam int CB           = 7;
  localparam int DRAIN_CYCLES = 12;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [KERN_W-1:0] cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [PIX_W-1:0]  pixel     = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PIX_W-1:0]  value;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic              frame_end;

  window_filter_3x3 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_i     (pixel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_o     (value),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .frame_end_o (frame_end)
  );

  // predictor copy of the configuration and the window state
  mode_e             mode_q   = MODE_MEAN;
  logic [KERN_W-1:0] kern_a_q = '0;
  logic [KERN_W-1:0] kern_b_q = '0;
  logic [11:0]       width_q  = WIDTH_RST;
  logic [12:0]       height_q = HEIGHT_RST;
  logic [PIX_W-1:0]  upper_line [LB_DEPTH];
  logic [PIX_W-1:0]  lower_line [LB_DEPTH];
  logic [PIX_W-1:0]  win_q [6];
  int                col_q = 0;
  int                row_q = 0;

  logic [PIX_W-1:0]  raster_q [$];
  filt_res_t         due_results [$];
  int                pixels_taken = 0;
  int                random_px = 0;
  int                errors = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int coef(input logic [KERN_W-1:0] kern, input int k);
    logic signed [CB-1:0] c;
    c = kern[k*CB +: CB];
    return int'(c);
  endfunction

  function automatic logic [PIX_W-1:0] shade(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] x;
    x = PIX_MAX - v;
    if (x < THR_1) return 8'd0;
    if (x < THR_2) return LVL_1;
    if (x < THR_3) return LVL_2;
    return PIX_MAX;
  endfunction

  function automatic logic [PIX_W-1:0] rim_value(input logic [PIX_W-1:0] centre);
    case (mode_q)
      MODE_MEAN:      return 8'd0;
      MODE_GRAD_POST: return shade(centre);
      default:        return centre;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] interior_value(input pix9_t w9);
    int sum, sa, sb, g;
    sum = 0;
    sa  = 0;
    sb  = 0;
    for (int k = 0; k < 9; k++) begin
      sum += int'(w9[k]);
      sa  += coef(kern_a_q, k) * int'(w9[k]);
      sb  += coef(kern_b_q, k) * int'(w9[k]);
    end
    case (mode_q)
      MODE_MEAN:   return PIX_W'(sum / 9);
      MODE_KERNEL: return sa < 0 ? 8'd0 : (sa > 255 ? PIX_MAX : PIX_W'(sa));
      default: begin
        g = (sa < 0 ? -sa : sa) + (sb < 0 ? -sb : sb);
        if (g > 255) g = 255;
        return mode_q == MODE_GRAD ? PIX_W'(g) : shade(PIX_W'(g));
      end
    endcase
  endfunction

  function automatic void queue_result(input logic [PIX_W-1:0] v, input int r, input int c,
                                       input logic fe);
    filt_res_t res;
    res.value     = v;
    res.row       = ROW_W'(r);
    res.col       = COL_W'(c);
    res.frame_end = fe;
    due_results.push_back(res);
  endfunction

  // one accepted pixel: results for the neighbourhoods it completes, then shift
  function automatic void advance_window(input logic [PIX_W-1:0] px);
    int w, h, r, c;
    logic [PIX_W-1:0] up, lo;
    pix9_t w9;
    w = width_q < 3 ? 3 : (width_q > LB_DEPTH ? LB_DEPTH : int'(width_q));
    h = height_q < 3 ? 3 : (height_q > ROWS_MAX ? ROWS_MAX : int'(height_q));
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
    end
    if (row_q >= h) row_q = 0;
    r  = row_q;
    c  = col_q;
    up = upper_line[c];
    lo = lower_line[c];
    w9[0] = win_q[3]; w9[1] = win_q[0]; w9[2] = up;
    w9[3] = win_q[4]; w9[4] = win_q[1]; w9[5] = lo;
    w9[6] = win_q[5]; w9[7] = win_q[2]; w9[8] = px;
    if (r >= 1) begin
      if (c >= 1)
        queue_result((r >= 2 && c >= 2) ? interior_value(w9) : rim_value(w9[4]),
                     r - 1, c - 1, 1'b0);
      if (c == w - 1) queue_result(rim_value(lo), r - 1, c, 1'b0);
    end
    if (r == h - 1) queue_result(rim_value(px), r, c, c == w - 1);
    win_q[3] = win_q[0];
    win_q[4] = win_q[1];
    win_q[5] = win_q[2];
    win_q[0] = up;
    win_q[1] = lo;
    win_q[2] = px;
    upper_line[c] = lo;
    lower_line[c] = px;
    col_q = c + 1;
    if (col_q == w) begin
      col_q = 0;
      row_q = r + 1;
      if (row_q == h) row_q = 0;
    end
  endfunction

  function automatic void field_check(input string name, input int e, input int a,
                                      input filt_res_t exp_r);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch at row %0d col %0d: expected %0d, actual %0d",
               $time, name, exp_r.row, exp_r.col, e, a);
    end
  endfunction

  function automatic void check_result();
    filt_res_t exp_r;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual value %0d row %0d col %0d",
               $time, value, out_row, out_col);
      return;
    end
    exp_r = due_results.pop_front();
    field_check("value", int'(exp_r.value), int'(value), exp_r);
    field_check("out_row", int'(exp_r.row), int'(out_row), exp_r);
    field_check("out_col", int'(exp_r.col), int'(out_col), exp_r);
    field_check("frame_end", int'(exp_r.frame_end), int'(frame_end), exp_r);
  endfunction

  // idling schedule: sender-light, then receiver-light, then flat out
  function automatic int send_gap_pct();
    return pixels_taken < 100 ? 23 : (pixels_taken < 200 ? 68 : 0);
  endfunction

  function automatic int recv_stall_pct();
    return pixels_taken < 100 ? 68 : (pixels_taken < 200 ? 23 : 0);
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        advance_window(pixel);
        pixels_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (raster_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
          in_valid <= 1'b1;
          pixel    <= raster_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      out_stall <= $urandom_range(0, 99) < recv_stall_pct();
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [KERN_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:   mode_q   = mode_e'(data[1:0]);
      REG_KERN_A: kern_a_q = data;
      REG_KERN_B: kern_b_q = data;
      REG_WIDTH:  width_q  = data[11:0];
      REG_HEIGHT: height_q = data[12:0];
      default: ;
    endcase
  endtask

  // wait for every transfer to land, then let the pipe empty
  task automatic settle();
    while (raster_q.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return PIX_MAX;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [KERN_W-1:0] make_kernel(input kern_style_e style);
    logic [KERN_W-1:0] kern;
    int v;
    kern = '0;
    for (int k = 0; k < 9; k++) begin
      case (style)
        KS_WIDE:  v = int'($urandom_range(0, 127)) - 64;
        KS_SMALL: v = int'($urandom_range(0, 6)) - 3;
        default: begin
          case ($urandom_range(0, 3))
            0:       v = -64;
            1:       v = 63;
            2:       v = -1;
            default: v = 0;
          endcase
        end
      endcase
      kern[k*CB +: CB] = CB'(v);
    end
    return kern;
  endfunction

  task automatic push_frames(input int w, input int h, input int n);
    for (int i = 0; i < w * h * n; i++) raster_q.push_back(rand_pixel());
    random_px += w * h * n;
  endtask

  initial begin
    int w_set, h_set, phase;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    foreach (win_q[i]) win_q[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // full-scale mean: nine saturated pixels
    write_reg(REG_MODE, KERN_W'(MODE_MEAN));
    write_reg(REG_KERN_A, {9{7'h3F}});
    write_reg(REG_KERN_B, '1);
    write_reg(REG_WIDTH, KERN_W'(3));
    write_reg(REG_HEIGHT, KERN_W'(3));
    repeat (9) raster_q.push_back(PIX_MAX);
    settle();

    // most negative kernel: interior clamps low, rim copied
    write_reg(REG_MODE, KERN_W'(MODE_KERNEL));
    write_reg(REG_KERN_A, {9{7'h40}});
    for (int i = 0; i < 9; i++) raster_q.push_back(i[0] ? PIX_MAX : 8'd0);
    settle();

    // oversize width clamps to the buffer depth; then shrink mid-frame
    write_reg(REG_MODE, KERN_W'(MODE_GRAD_POST));
    write_reg(REG_KERN_A, {9{7'h3F}});
    write_reg(REG_WIDTH, KERN_W'(12'hFFF));
    repeat (4) raster_q.push_back(rand_pixel());
    settle();
    write_reg(REG_WIDTH, KERN_W'(0));
    write_reg(REG_HEIGHT, KERN_W'(13'h1FFF));
    repeat (3) raster_q.push_back(rand_pixel());
    settle();
    write_reg(REG_HEIGHT, KERN_W'(0));
    repeat (3) raster_q.push_back(rand_pixel());
    settle();

    phase = 0;
    while (random_px < 220) begin
      write_reg(REG_MODE, KERN_W'(phase[1:0]));
      write_reg(REG_KERN_A, make_kernel(kern_style_e'($urandom_range(0, 2))));
      write_reg(REG_KERN_B, make_kernel(kern_style_e'($urandom_range(0, 2))));
      w_set = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      h_set = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      write_reg(REG_WIDTH, KERN_W'(w_set));
      write_reg(REG_HEIGHT, KERN_W'(h_set));
      push_frames(w_set < 3 ? 3 : w_set, h_set < 3 ? 3 : h_set, $urandom_range(1, 2));
      settle();
      phase++;
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
